/* design/bsf_pkg.sv */
`timescale 1ns / 1ps

package bsf_pkg;

   // Command codes carried in req_tuser
   localparam logic [1:0] OP_FILL  = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   // Configuration register indexes
   localparam logic CFG_WIDTH_PX    = 1'b0;
   localparam logic CFG_HEIGHT_ROWS = 1'b1;

   // Field widths of the stream words
   localparam int ROW_W   = 10;
   localparam int X_W     = 11;
   localparam int WI_W    = 5;
   localparam int SIZE_W  = 11;

   // Row tags: a row is valid when its tag equals the current epoch
   localparam int EPOCH_W = 8;

   // Width used for size and index comparisons
   localparam int CMP_W   = 16;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

   // Controller to datapath commands
   typedef struct packed {
      logic accept;          // latch the request word
      logic issue_look;      // read row tag, and the word for a read
      logic do_clear;        // advance epoch, drop last row
      logic set_read_result; // capture the read word
      logic mark_row;        // tag the row and raise the last row
      logic load_k_first;    // start the word counter at the first span word
      logic load_k_zero;     // start the word counter at word zero
      logic zfill_write;     // write the span mask over the whole row
      logic rmw_read;        // read word k for an OR update
      logic sweep_write;     // clear one row tag
      logic load_rsp;        // load the result register
   } ctl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic [1:0] opcode;
      logic       range_err;
      logic       row_match;
      logic       span_empty;
      logic       k_at_last;
      logic       k_at_end;
      logic       sweep_done;
      logic       epoch_full;
      logic       rsp_busy;
   } dp_status_type;

   // Ones below bit n, n from 0 to 32
   function automatic logic [31:0] low_ones(input logic [5:0] n);
      logic [31:0] v;
      if (n >= 6'd32) v = 32'hffff_ffff;
      else v = (32'h1 << n[4:0]) - 32'h1;
      return v;
   endfunction

   // Pixels of word kk that lie in the span [xs, xe)
   function automatic logic [31:0] span_mask(input logic [CMP_W-1:0] kk,
                                             input logic [X_W-1:0] xs,
                                             input logic [X_W-1:0] xe);
      logic [CMP_W-1:0] first;
      logic [CMP_W-1:0] last;
      logic [5:0]       lo;
      logic [5:0]       hi;
      first = CMP_W'(xs[X_W-1:5]);
      last  = CMP_W'(xe[X_W-1:5]);
      if (kk < first) lo = 6'd32;
      else if (kk == first) lo = {1'b0, xs[4:0]};
      else lo = 6'd0;
      if (kk > last) hi = 6'd0;
      else if (kk == last) hi = {1'b0, xe[4:0]};
      else hi = 6'd32;
      return low_ones(hi) & ~low_ones(lo);
   endfunction

endpackage

/* design/bsf_ram.sv */
`timescale 1ns / 1ps

module bsf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, read one entry into the output register
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/bsf_ctl.sv */
`timescale 1ns / 1ps

module bsf_ctl
   import bsf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type sts,
   output ctl_cmd_type   cmd
);

   typedef enum logic [7:0] {
      S_SWEEP  = 8'b0000_0001,
      S_IDLE   = 8'b0000_0010,
      S_CHECK  = 8'b0000_0100,
      S_TAG    = 8'b0000_1000,
      S_ZFILL  = 8'b0001_0000,
      S_RMW    = 8'b0010_0000,
      S_WB     = 8'b0100_0000,
      S_FINISH = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      sweep_next_ff, sweep_next_in;

   // Next state and commands
   always_comb begin
      state_in      = state_ff;
      sweep_next_in = sweep_next_ff;
      cmd           = '0;
      req_ready     = 1'b0;
      unique case (state_ff)
         S_SWEEP: begin
            cmd.sweep_write = 1'b1;
            if (sts.sweep_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.range_err) begin
               state_in = S_FINISH;
            end else begin
               unique case (sts.opcode) inside
                  OP_FILL, OP_READ: begin
                     cmd.issue_look = 1'b1;
                     state_in       = S_TAG;
                  end
                  OP_CLEAR: begin
                     cmd.do_clear  = 1'b1;
                     sweep_next_in = sts.epoch_full;
                     state_in      = S_FINISH;
                  end
                  default: state_in = S_FINISH;
               endcase
            end
         end
         S_TAG: begin
            if (sts.opcode == OP_READ) begin
               cmd.set_read_result = 1'b1;
               state_in            = S_FINISH;
            end else if (sts.row_match) begin
               if (sts.span_empty) begin
                  state_in = S_FINISH;
               end else begin
                  cmd.load_k_first = 1'b1;
                  state_in         = S_RMW;
               end
            end else begin
               cmd.mark_row    = 1'b1;
               cmd.load_k_zero = 1'b1;
               state_in        = S_ZFILL;
            end
         end
         S_ZFILL: begin
            cmd.zfill_write = 1'b1;
            if (sts.k_at_end) state_in = S_FINISH;
         end
         S_RMW: begin
            cmd.rmw_read = 1'b1;
            if (sts.k_at_last) state_in = S_WB;
         end
         S_WB: begin
            // last OR write goes out this cycle
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!sts.rsp_busy) begin
               cmd.load_rsp  = 1'b1;
               sweep_next_in = 1'b0;
               state_in      = sweep_next_ff ? S_SWEEP : S_IDLE;
            end
         end
         default: state_in = S_SWEEP;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_SWEEP;
         sweep_next_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_next_ff <= sweep_next_in;
      end
   end

endmodule

/* design/bsf_dp.sv */
`timescale 1ns / 1ps

module bsf_dp
   import bsf_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic              csr_index,
   input  logic [SIZE_W-1:0] csr_wdata,
   input  logic [1:0]        req_opcode,
   input  logic [ROW_W-1:0]  req_row,
   input  logic [X_W-1:0]    req_x_start,
   input  logic [X_W-1:0]    req_x_end,
   input  logic [WI_W-1:0]   req_word_index,
   input  ctl_cmd_type       cmd,
   output dp_status_type     sts,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output logic [31:0]       rsp_read_word,
   output logic [ROW_W-1:0]  rsp_last_row,
   output logic              rsp_status
);

   localparam int WPR   = (MAX_WIDTH + 31) / 32;
   localparam int KW    = (WPR > 1) ? $clog2(WPR) : 1;
   localparam int DEPTH = MAX_HEIGHT * WPR;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int HA_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

   localparam logic [CMP_W-1:0] MAXW     = CMP_W'(MAX_WIDTH);
   localparam logic [CMP_W-1:0] MAXH     = CMP_W'(MAX_HEIGHT);
   localparam logic [CMP_W-1:0] WPR_C    = CMP_W'(WPR);
   localparam logic [CMP_W-1:0] WPR_LAST = CMP_W'(WPR - 1);
   localparam logic [HA_W-1:0]  ROW_LAST = HA_W'(MAX_HEIGHT - 1);

   // Configuration registers
   logic [SIZE_W-1:0] width_ff, height_ff;

   // Latched request word
   logic [1:0]       op_ff;
   logic [ROW_W-1:0] row_ff;
   logic [X_W-1:0]   xs_ff, xe_ff;
   logic [WI_W-1:0]  wi_ff;

   // Word counter and pending OR write
   logic [KW-1:0] k_ff, k_in;
   logic [KW-1:0] kw_ff;
   logic          pend_ff;

   logic [EPOCH_W-1:0] epoch_ff;
   logic [HA_W-1:0]    sweep_cnt_ff;
   logic [ROW_W-1:0]   last_row_ff;
   logic [31:0]        read_res_ff;

   logic              rsp_valid_ff;
   logic [31:0]       rsp_word_ff;
   logic [ROW_W-1:0]  rsp_last_ff;
   logic              rsp_status_ff;

   // RAM ports
   logic               word_wr_en, word_rd_en;
   logic [AW-1:0]      word_wr_addr, word_rd_addr;
   logic [31:0]        word_wr_data, word_rd_data;
   logic               tag_wr_en;
   logic [HA_W-1:0]    tag_wr_addr, tag_rd_addr;
   logic [EPOCH_W-1:0] tag_wr_data, tag_rd_data;

   logic [CMP_W-1:0] w_eff, h_eff, words, first_w, raw_last, last_eff;
   logic             fill_err, read_err, range_err;

   function automatic logic [AW-1:0] word_addr(input logic [ROW_W-1:0] r,
                                               input logic [CMP_W-1:0] kk);
      logic [31:0] a;
      a = 32'(r) * 32'(WPR) + 32'(kk);
      return a[AW-1:0];
   endfunction

   // Effective sizes and range checks
   always_comb begin
      if (width_ff == '0) w_eff = CMP_W'(1);
      else if (CMP_W'(width_ff) > MAXW) w_eff = MAXW;
      else w_eff = CMP_W'(width_ff);
      if (height_ff == '0) h_eff = CMP_W'(1);
      else if (CMP_W'(height_ff) > MAXH) h_eff = MAXH;
      else h_eff = CMP_W'(height_ff);
      words    = (w_eff + CMP_W'(31)) >> 5;
      first_w  = CMP_W'(xs_ff[X_W-1:5]);
      raw_last = CMP_W'(xe_ff[X_W-1:5]);
      last_eff = (raw_last > WPR_LAST) ? WPR_LAST : raw_last;
      fill_err = (CMP_W'(row_ff) >= h_eff) || (CMP_W'(xe_ff) > w_eff) || (xs_ff > xe_ff);
      read_err = (CMP_W'(row_ff) >= h_eff) || (CMP_W'(wi_ff) >= words)
              || (CMP_W'(wi_ff) >= WPR_C);
      case (op_ff)
         OP_FILL:  range_err = fill_err;
         OP_READ:  range_err = read_err;
         OP_CLEAR: range_err = 1'b0;
         default:  range_err = 1'b1;
      endcase
   end

   // Status to the controller
   always_comb begin
      sts.opcode     = op_ff;
      sts.range_err  = range_err;
      sts.row_match  = (tag_rd_data == epoch_ff);
      sts.span_empty = (first_w > last_eff);
      sts.k_at_last  = (CMP_W'(k_ff) == last_eff);
      sts.k_at_end   = (CMP_W'(k_ff) == WPR_LAST);
      sts.sweep_done = (sweep_cnt_ff == ROW_LAST);
      sts.epoch_full = (epoch_ff == '1);
      sts.rsp_busy   = rsp_valid_ff && !rsp_ready;
   end

   // Pixel word port selection
   always_comb begin
      word_rd_en   = cmd.issue_look || cmd.rmw_read;
      word_rd_addr = cmd.rmw_read ? word_addr(row_ff, CMP_W'(k_ff))
                                  : word_addr(row_ff, CMP_W'(wi_ff));
      word_wr_en   = cmd.zfill_write || pend_ff;
      if (pend_ff) begin
         word_wr_addr = word_addr(row_ff, CMP_W'(kw_ff));
         word_wr_data = word_rd_data | span_mask(CMP_W'(kw_ff), xs_ff, xe_ff);
      end else begin
         word_wr_addr = word_addr(row_ff, CMP_W'(k_ff));
         word_wr_data = span_mask(CMP_W'(k_ff), xs_ff, xe_ff);
      end
   end

   // Row tag port selection
   always_comb begin
      tag_rd_addr = HA_W'(row_ff);
      tag_wr_en   = cmd.sweep_write || cmd.mark_row;
      tag_wr_addr = cmd.sweep_write ? sweep_cnt_ff : HA_W'(row_ff);
      tag_wr_data = cmd.sweep_write ? '0 : epoch_ff;
   end

   // Word counter
   always_comb begin
      k_in = k_ff;
      if (cmd.load_k_first) k_in = first_w[KW-1:0];
      else if (cmd.load_k_zero) k_in = '0;
      else if (cmd.zfill_write || cmd.rmw_read) k_in = k_ff + KW'(1);
   end

   bsf_ram #(
      .WIDTH(32),
      .DEPTH(DEPTH)
   ) u_words (
      .clock  (clock),
      .wr_en  (word_wr_en),
      .wr_addr(word_wr_addr),
      .wr_data(word_wr_data),
      .rd_en  (word_rd_en),
      .rd_addr(word_rd_addr),
      .rd_data(word_rd_data)
   );

   bsf_ram #(
      .WIDTH(EPOCH_W),
      .DEPTH(MAX_HEIGHT)
   ) u_tags (
      .clock  (clock),
      .wr_en  (tag_wr_en),
      .wr_addr(tag_wr_addr),
      .wr_data(tag_wr_data),
      .rd_en  (cmd.issue_look),
      .rd_addr(tag_rd_addr),
      .rd_data(tag_rd_data)
   );

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SIZE_RESET;
         height_ff <= SIZE_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CFG_WIDTH_PX:    width_ff  <= csr_wdata;
            CFG_HEIGHT_ROWS: height_ff <= csr_wdata;
            default:         width_ff  <= width_ff;
         endcase
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff  <= req_opcode;
         row_ff <= req_row;
         xs_ff  <= req_x_start;
         xe_ff  <= req_x_end;
         wi_ff  <= req_word_index;
      end
      k_ff <= k_in;
      if (cmd.rmw_read) kw_ff <= k_ff;
      if (cmd.accept) read_res_ff <= '0;
      else if (cmd.set_read_result)
         read_res_ff <= (tag_rd_data == epoch_ff) ? word_rd_data : '0;
      if (cmd.load_rsp) begin
         rsp_word_ff   <= read_res_ff;
         rsp_last_ff   <= last_row_ff;
         rsp_status_ff <= range_err;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         epoch_ff     <= EPOCH_W'(1);
         sweep_cnt_ff <= '0;
         last_row_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff <= cmd.rmw_read;
         if (cmd.do_clear) epoch_ff <= (epoch_ff == '1) ? EPOCH_W'(1) : epoch_ff + EPOCH_W'(1);
         if (cmd.sweep_write) sweep_cnt_ff <= (sweep_cnt_ff == ROW_LAST) ? '0
                                                                         : sweep_cnt_ff + HA_W'(1);
         if (cmd.do_clear) last_row_ff <= '0;
         else if (cmd.mark_row && (row_ff > last_row_ff)) last_row_ff <= row_ff;
         if (cmd.load_rsp) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_word = rsp_word_ff;
   assign rsp_last_row  = rsp_last_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

/* design/bitmap_span_fill_top.sv */
`timescale 1ns / 1ps
// channel   direction  handshake              payload
// req       in         req_tvalid/req_tready  tuser opcode, tdata row/x_start/x_end/word_index
// rsp       out        rsp_tvalid/rsp_tready  tuser status, tdata read_word/last_row_touched
// csr       in         csr_wr_en              csr_index, csr_wdata (write only)
//
// One command at a time. A fill of an untouched row writes the whole row once, one word a
// cycle; a fill of a touched row does a read-modify-write of each span word over the word
// RAM and writes nothing when no span word is left. Reset, and every 255th clear, run a tag
// sweep, one row a cycle, with req_tready low. A result waits in the output register; the
// next command is taken meanwhile and stalls only at its end.
module bitmap_span_fill_top
   import bsf_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [39:0]       req_tdata,   // row[9:0], x_start[20:10], x_end[31:21],
                                          // word_index[36:32], zero[39:37]
   input  logic [1:0]        req_tuser,   // opcode[1:0]
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [47:0]       rsp_tdata,   // read_word[31:0], last_row_touched[41:32],
                                          // zero[47:42]
   output logic              rsp_tuser,   // status[0]
   input  logic              csr_wr_en,
   input  logic              csr_index,
   input  logic [SIZE_W-1:0] csr_wdata
);

   ctl_cmd_type      ctl_cmd;
   dp_status_type    dp_sts;
   logic [31:0]      rsp_word;
   logic [ROW_W-1:0] rsp_last;

   bsf_ctl u_ctl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_tvalid),
      .req_ready(req_tready),
      .sts      (dp_sts),
      .cmd      (ctl_cmd)
   );

   bsf_dp #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_opcode    (req_tuser),
      .req_row       (req_tdata[9:0]),
      .req_x_start   (req_tdata[20:10]),
      .req_x_end     (req_tdata[31:21]),
      .req_word_index(req_tdata[36:32]),
      .cmd           (ctl_cmd),
      .sts           (dp_sts),
      .rsp_ready     (rsp_tready),
      .rsp_valid     (rsp_tvalid),
      .rsp_read_word (rsp_word),
      .rsp_last_row  (rsp_last),
      .rsp_status    (rsp_tuser)
   );

   assign rsp_tdata = {6'd0, rsp_last, rsp_word};

   // One command in flight: no second word right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while a command is in flight");

   // Result register is loaded only when its slot is free
   a_rsp_slot_free: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.load_rsp |-> !dp_sts.rsp_busy)
      else $error("result loaded over a waiting word");

   // A loaded result is presented on the next cycle
   a_rsp_shown: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.load_rsp |=> rsp_tvalid)
      else $error("loaded result not presented");

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench
   import bsf_pkg::*;
();

   localparam int ROWS        = 1024;
   localparam int ROW_WORDS   = 32;
   localparam int CYCLE_LIMIT = 1000000;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = OP_NONE;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_wr_en  = 1'b0;
   logic        csr_index  = CFG_WIDTH_PX;
   logic [SIZE_W-1:0] csr_wdata = '0;

   int cycles = 0;
   bit calm   = 1'b0;   // no idling on either side while set
   int cur_w  = 1024;   // sizes in effect, after clamping
   int cur_h  = 1024;

   typedef struct {
      bit [31:0] word;
      bit [9:0]  top;
      bit        status;
   } span_result_type;

   // Shadow bitmap: predicts each response word and checks it on arrival
   class span_fill_shadow;
      bit [31:0]       pixels [ROWS][ROW_WORDS];
      bit              row_live [ROWS];
      bit [9:0]        top_row;
      bit [10:0]       width_reg;
      bit [10:0]       height_reg;
      span_result_type expected [$];
      int              errors;

      function new();
         width_reg  = SIZE_RESET;
         height_reg = SIZE_RESET;
         top_row    = '0;
         errors     = 0;
         foreach (row_live[i]) row_live[i] = 1'b0;
      endfunction

      function int usable(bit [10:0] v);
         if (v == 0) return 1;
         if (v > 1024) return 1024;
         return int'(v);
      endfunction

      function bit [31:0] ones_below(int n);
         if (n >= 32) return 32'hffff_ffff;
         return (32'h1 << n) - 32'h1;
      endfunction

      function void set_size(logic idx, bit [10:0] v);
         if (idx == CFG_WIDTH_PX) width_reg = v;
         else height_reg = v;
      endfunction

      function int pending();
         return expected.size();
      endfunction

      // Work out the response to one accepted command
      function void note_command(bit [1:0] op, bit [9:0] row, bit [10:0] xs,
                                 bit [10:0] xe, bit [4:0] wi);
         span_result_type r;
         int w;
         int h;
         int first;
         int last;
         int lo;
         int hi;
         w = usable(width_reg);
         h = usable(height_reg);
         r.word   = '0;
         r.status = 1'b0;
         case (op)
            OP_FILL: begin
               if (row >= h || xe > w || xs > xe) begin
                  r.status = 1'b1;
               end else begin
                  first = xs / 32;
                  last  = xe / 32;
                  // first touch zeroes the row and may raise the top row
                  if (!row_live[row]) begin
                     for (int k = 0; k < ROW_WORDS; k++) pixels[row][k] = '0;
                     row_live[row] = 1'b1;
                     if (row > top_row) top_row = row;
                  end
                  for (int k = first; k <= last && k < ROW_WORDS; k++) begin
                     lo = (k == first) ? xs % 32 : 0;
                     hi = (k == last) ? xe % 32 : 32;
                     pixels[row][k] |= ones_below(hi) & ~ones_below(lo);
                  end
               end
            end
            OP_READ: begin
               if (row >= h || wi >= (w + 31) / 32) r.status = 1'b1;
               else if (row_live[row]) r.word = pixels[row][wi];
            end
            OP_CLEAR: begin
               foreach (row_live[i]) row_live[i] = 1'b0;
               top_row = '0;
            end
            default: r.status = 1'b1;
         endcase
         r.top = top_row;
         expected = {expected, r};
      endfunction

      // Compare one accepted response word with the oldest prediction
      function void check_result(bit [31:0] word, bit [9:0] top, bit status);
         span_result_type e;
         if (expected.size() == 0) begin
            $error("response word with no command outstanding");
            errors++;
            return;
         end
         e = expected.pop_front();
         if (word !== e.word) begin
            $error("read_word expected %h actual %h", e.word, word);
            errors++;
         end
         if (top !== e.top) begin
            $error("last_row_touched expected %0d actual %0d", e.top, top);
            errors++;
         end
         if (status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, status);
            errors++;
         end
      endfunction
   endclass

   span_fill_shadow shadow = new();

   bitmap_span_fill_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6;
      clock = 1'b1;
      #6;
      clock = 1'b0;
   end

   // Idle length: mostly none or short, now and then long
   function int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm) return 0;
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Send one command word and note it once accepted
   task automatic issue_cmd(logic [1:0] op, int row, int xs, int xe, int wi);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {3'b000, 5'(wi), 11'(xe), 11'(xs), 10'(row)};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      shadow.note_command(op, 10'(row), 11'(xs), 11'(xe), 5'(wi));
   endtask

   // Write one size register once the block has gone quiet
   task automatic write_size(logic idx, logic [10:0] v);
      while (shadow.pending() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      shadow.set_size(idx, v);
   endtask

   task automatic set_sizes(int w, int h);
      req_tvalid <= 1'b0;
      write_size(CFG_WIDTH_PX, 11'(w));
      write_size(CFG_HEIGHT_ROWS, 11'(h));
      cur_w = shadow.usable(11'(w));
      cur_h = shadow.usable(11'(h));
   endtask

   // Rows mostly from a small pool so reads land on filled rows
   function int pool_row();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return $urandom_range(0, ((cur_h < 8) ? cur_h : 8) - 1);
      if (r < 7) return cur_h - 1;
      return $urandom_range(0, cur_h - 1);
   endfunction

   task automatic random_fill();
      int a;
      int b;
      int t;
      int k;
      k = $urandom_range(0, 9);
      if (k < 4) begin
         a = $urandom_range(0, cur_w);
         b = $urandom_range(0, cur_w);
         if (a > b) begin
            t = a;
            a = b;
            b = t;
         end
      end else if (k < 7) begin
         a = $urandom_range(0, cur_w);
         b = a + $urandom_range(0, 40);
         if (b > cur_w) b = cur_w;
      end else if (k == 7) begin
         a = 0;
         b = cur_w;
      end else if (k == 8) begin
         a = $urandom_range(0, cur_w);
         b = a;
      end else begin
         a = 32 * $urandom_range(0, cur_w / 32);
         b = a + 32 * $urandom_range(0, 3);
         if (b > cur_w) b = cur_w;
      end
      issue_cmd(OP_FILL, pool_row(), a, b, $urandom_range(0, 31));
   endtask

   // Random commands: well-formed fills and reads, some clears, some junk
   task automatic random_burst(int n, int clear_pct);
      int r;
      for (int i = 0; i < n; i++) begin
         if (i % 50 == 0) calm = ($urandom_range(0, 3) == 0);
         r = $urandom_range(0, 99);
         if (r < clear_pct) begin
            issue_cmd(OP_CLEAR, $urandom_range(0, 1023), $urandom_range(0, 2047),
                      $urandom_range(0, 2047), $urandom_range(0, 31));
         end else begin
            r = $urandom_range(0, 99);
            if (r < 48) begin
               random_fill();
            end else if (r < 82) begin
               issue_cmd(OP_READ, pool_row(), $urandom_range(0, 2047),
                         $urandom_range(0, 2047),
                         $urandom_range(0, (cur_w + 31) / 32 - 1));
            end else begin
               case ($urandom_range(0, 2))
                  0: issue_cmd(OP_NONE, $urandom_range(0, 1023), $urandom_range(0, 2047),
                               $urandom_range(0, 2047), $urandom_range(0, 31));
                  1: issue_cmd(OP_FILL, $urandom_range(0, 1023), $urandom_range(0, 2047),
                               $urandom_range(0, 2047), $urandom_range(0, 31));
                  default: issue_cmd(OP_READ, $urandom_range(0, 1023),
                                     $urandom_range(0, 2047), $urandom_range(0, 2047),
                                     $urandom_range(0, 31));
               endcase
            end
         end
      end
      calm = 1'b0;
   endtask

   // Response side: check each accepted word, stall at random
   initial begin
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready)
            shadow.check_result(rsp_tdata[31:0], rsp_tdata[41:32], rsp_tuser);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 99) < 30) stall = pick_gap();
         end
      end
   end

   // Hard stop on a hang
   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed commands at the reset sizes
      issue_cmd(OP_READ, 0, 0, 0, 0);          // row never touched
      issue_cmd(OP_FILL, 0, 0, 1024, 0);       // whole row
      issue_cmd(OP_READ, 0, 0, 0, 0);
      issue_cmd(OP_READ, 0, 0, 0, 31);
      issue_cmd(OP_FILL, 1023, 5, 5, 0);       // empty span still raises top row
      issue_cmd(OP_READ, 1023, 0, 0, 0);
      issue_cmd(OP_FILL, 3, 31, 33, 0);        // span across a word boundary
      issue_cmd(OP_READ, 3, 0, 0, 0);
      issue_cmd(OP_READ, 3, 0, 0, 1);
      issue_cmd(OP_FILL, 3, 64, 96, 0);        // span ending on a word boundary
      issue_cmd(OP_READ, 3, 0, 0, 2);
      issue_cmd(OP_READ, 3, 0, 0, 3);
      issue_cmd(OP_FILL, 5, 1000, 1025, 0);    // end past the width
      issue_cmd(OP_FILL, 5, 10, 9, 0);         // start after end
      issue_cmd(OP_FILL, 5, 2047, 2047, 0);
      issue_cmd(OP_NONE, 1023, 2047, 2047, 31);
      issue_cmd(OP_FILL, 3, 1024, 1024, 31);   // empty span at the right edge
      issue_cmd(OP_READ, 1023, 2047, 2047, 31);
      issue_cmd(OP_CLEAR, 0, 0, 0, 0);
      issue_cmd(OP_READ, 0, 0, 0, 0);          // cleared row reads zero
      issue_cmd(OP_FILL, 2, 1, 2, 0);
      issue_cmd(OP_READ, 2, 0, 0, 0);

      // Random phases over a range of sizes, shrinking without clearing
      set_sizes(1024, 1024);
      random_burst(250, 3);
      set_sizes(40, 6);
      random_burst(200, 3);
      set_sizes(1, 1);
      random_burst(80, 3);
      set_sizes(0, 0);
      random_burst(60, 3);
      set_sizes(2047, 2047);
      random_burst(150, 3);
      // long run of clears to wrap the row tags
      set_sizes(1024, 3);
      random_burst(280, 85);
      set_sizes(700, 300);
      random_burst(250, 3);
      set_sizes(32, 1024);
      random_burst(100, 3);
      req_tvalid <= 1'b0;

      // Drain, then allow for stray words
      while (shadow.pending() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (shadow.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

/* bitmap_span_fill_top.f */
design/bsf_pkg.sv
design/bsf_ram.sv
design/bsf_ctl.sv
design/bsf_dp.sv
design/bitmap_span_fill_top.sv
tb/sv/testbench.sv
